// File: sv/rsmca_pkg.sv
// shared types, constants and the cordic arctangent table for the ring slot assignment block
`timescale 1ns / 1ps
package rsmca_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ANGLE,
    ST_ROT,
    ST_MULX,
    ST_MULY,
    ST_MULW,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SQADD,
    ST_ROOT,
    ST_ACC,
    ST_CMP,
    ST_OUT
  } rsmca_state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_PHASE_STEPS = 2'd0;
  localparam logic [1:0] CFG_MIN_HEIGHT  = 2'd1;

  localparam logic [6:0]  PHASE_STEPS_RST = 7'd36;
  localparam logic [20:0] MIN_HEIGHT_RST  = 21'd512;
  localparam logic [6:0]  STEPS_MIN       = 7'd4;
  localparam logic [6:0]  STEPS_MAX       = 7'd64;

  localparam logic [25:0] COST_MAX = 26'h3ff_ffff;
  localparam logic [30:0] DIFF_CAP = 31'h7fff_ffff;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam int TRIG_TABLE_LEN = 24;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/ring_slot_min_cost_assignment.sv
// top level: exhaustive ring slot assignment search with serial trig and root units
`timescale 1ns / 1ps
// Usage
// Input channel (in_valid / in_stall): one agent position per item. The item with
// in_final_agent set also carries the ring center and radius and starts a search.
// Agent items beyond AGENTS before a final item are dropped.
// Config port (cfg_valid / cfg_ready, always ready): index 0 phase steps (clamped
// to 4..64), index 1 minimum slot height. Write only while the block is idle.
// Result channel (out_valid / out_stall): AGENTS items per search, in agent order,
// out_final_result on the last one. A stalled result holds until taken.
// Sequence: a search runs the 2^32/S divider, then for each phase step the cordic
// and radius multiplies for every slot and, for every permutation, one distance
// per agent and a compare; its length is set by the bit-serial square root and the
// one-step-per-cycle cordic, and the results follow. in_stall is high from the
// final item until the last result is taken, so items are handled one at a time.
// Reset: configuration returns to 36 phase steps and height 512, load count to
// zero, the channels go idle; the position store keeps no reset value.
module ring_slot_min_cost_assignment
  import rsmca_pkg::*;
#(
  parameter int AGENTS     = 4,
  parameter int COORD_BITS = 22,
  parameter int TRIG_ITERS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_agent_x,
  input  logic signed [COORD_BITS-1:0] in_agent_y,
  input  logic signed [COORD_BITS-1:0] in_agent_z,
  input  logic signed [COORD_BITS-1:0] in_ring_center_x,
  input  logic signed [COORD_BITS-1:0] in_ring_center_y,
  input  logic signed [COORD_BITS-1:0] in_ring_center_z,
  input  logic [15:0]                  in_ring_radius,
  input  logic                         in_final_agent,
  // configuration port
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [20:0]                  cfg_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_agent_index,
  output logic [2:0]                   out_assigned_slot,
  output logic [5:0]                   out_best_phase_index,
  output logic [25:0]                  out_total_cost,
  output logic                         out_final_result
);

  localparam int IW    = $clog2(AGENTS);
  localparam int LCW   = $clog2(AGENTS + 1);
  localparam int ORW   = $clog2(AGENTS) + 1;
  localparam int WW    = (COORD_BITS + 4 > 32) ? COORD_BITS + 4 : 32;
  localparam int TRIGS = (TRIG_ITERS < TRIG_TABLE_LEN) ? TRIG_ITERS : TRIG_TABLE_LEN;
  localparam logic [63:0]    TURN   = 64'h1_0000_0000;
  localparam logic [31:0]    OFF_Q  = 32'(TURN / AGENTS);
  localparam logic [ORW-1:0] OFF_R  = ORW'(TURN % AGENTS);
  localparam logic [IW-1:0]  LAST_A = IW'(AGENTS - 1);

  rsmca_state_t state_r, state_nxt;

  // configuration
  logic [6:0]  phase_steps_r;
  logic [20:0] min_height_r;

  // position store and load count
  logic signed [COORD_BITS-1:0] pos_x_r [AGENTS];
  logic signed [COORD_BITS-1:0] pos_y_r [AGENTS];
  logic signed [COORD_BITS-1:0] pos_z_r [AGENTS];
  logic [LCW-1:0] load_cnt_r;

  // search constants latched from the final item
  logic signed [WW-1:0] cx_r, cy_r, zslot_r;
  logic [15:0] radius_r;
  logic [6:0]  steps_r;

  // 2^32 / S divider
  logic [6:0]  div_rem_r;
  logic [31:0] div_q_r;
  logic [5:0]  div_cnt_r;

  // phase and slot angle accumulators
  logic [5:0]     k_r;
  logic [31:0]    base_q_r;
  logic [6:0]     base_rem_r;
  logic [IW-1:0]  slot_r;
  logic [31:0]    off_q_r;
  logic [ORW-1:0] off_rem_r;

  // cordic
  logic signed [33:0] cor_x_r, cor_y_r, cor_z_r;
  logic               neg_r;
  logic [4:0]         it_r;
  logic signed [50:0] rprod_r;

  // slot positions of the current phase
  logic signed [WW-1:0] px_r [AGENTS];
  logic signed [WW-1:0] py_r [AGENTS];

  // permutations
  logic [IW-1:0] trial_r     [AGENTS];
  logic [IW-1:0] best_perm_r [AGENTS];
  logic [IW-1:0] perm_nxt    [AGENTS];
  logic          perm_more;

  // distance path
  logic [IW-1:0] ag_r;
  logic [30:0]   capx_r, capy_r, capz_r;
  logic [61:0]   sq_r;
  logic [63:0]   sum_r;
  logic [63:0]   sn_r;
  logic [33:0]   srem_r;
  logic [31:0]   sroot_r;
  logic [4:0]    scnt_r;
  logic [25:0]   total_r, best_total_r;
  logic [5:0]    best_phase_r;
  logic [IW-1:0] out_idx_r;

  logic in_acc, out_acc;

  // clamp a difference to magnitude 2^31-1
  function automatic logic [30:0] cap_abs(input logic signed [WW-1:0] d);
    logic [WW-1:0] m;
    m = d[WW-1] ? WW'(-d) : WW'(d);
    return (m > WW'(DIFF_CAP)) ? DIFF_CAP : m[30:0];
  endfunction

  // handshake outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = 1'b1;
    out_valid = (state_r == ST_OUT);
  end

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // result fields
  assign out_agent_index      = 3'(out_idx_r);
  assign out_assigned_slot    = 3'(best_perm_r[out_idx_r]);
  assign out_best_phase_index = best_phase_r;
  assign out_total_cost       = best_total_r;
  assign out_final_result     = (out_idx_r == LAST_A);

  // slot angle and its fold into the right half plane
  logic [31:0] angle, angle_q, ang_fold;
  logic        ang_neg;
  always_comb begin
    angle    = base_q_r + off_q_r;
    angle_q  = angle + 32'h4000_0000;
    ang_neg  = angle_q[31];
    ang_fold = ang_neg ? (angle + 32'h8000_0000) : angle;
  end

  // one cordic rotation step
  logic signed [33:0] sh_x, sh_y, atan_v, rot_x, rot_y, rot_z, cos_v, sin_v;
  always_comb begin
    sh_x   = cor_x_r >>> it_r;
    sh_y   = cor_y_r >>> it_r;
    atan_v = $signed({2'b00, atan_turn(it_r)});
    if (!cor_z_r[33]) begin
      rot_x = cor_x_r - sh_y;
      rot_y = cor_y_r + sh_x;
      rot_z = cor_z_r - atan_v;
    end else begin
      rot_x = cor_x_r + sh_y;
      rot_y = cor_y_r - sh_x;
      rot_z = cor_z_r + atan_v;
    end
    cos_v = neg_r ? -cor_x_r : cor_x_r;
    sin_v = neg_r ? -cor_y_r : cor_y_r;
  end

  // radius scaling and rounding
  logic signed [33:0] rmul_op;
  logic signed [50:0] rprod_v, rnd_v;
  logic signed [WW-1:0] roff_v;
  always_comb begin
    rmul_op = (state_r == ST_MULX) ? cos_v : sin_v;
    rprod_v = $signed({1'b0, radius_r}) * rmul_op;
    rnd_v   = rprod_r + 51'sd536870912;
    roff_v  = WW'(rnd_v >>> 30);
  end

  // agent to slot differences
  logic [IW-1:0] slot_sel;
  logic signed [WW-1:0] dx_v, dy_v, dz_v;
  always_comb begin
    slot_sel = trial_r[ag_r];
    dx_v = WW'(pos_x_r[ag_r]) - px_r[slot_sel];
    dy_v = WW'(pos_y_r[ag_r]) - py_r[slot_sel];
    dz_v = WW'(pos_z_r[ag_r]) - zslot_r;
  end

  // squaring multiplier
  logic [30:0] sq_op;
  logic [61:0] sq_v;
  always_comb begin
    case (state_r)
      ST_SQX:  sq_op = capx_r;
      ST_SQY:  sq_op = capy_r;
      default: sq_op = capz_r;
    endcase
    sq_v = sq_op * sq_op;
  end

  // one square root digit
  logic [35:0] rem2, rtry;
  logic        rge;
  always_comb begin
    rem2 = {srem_r, sn_r[63:62]};
    rtry = {2'b00, sroot_r, 2'b01};
    rge  = (rem2 >= rtry);
  end

  // saturating total
  logic [32:0] tsum;
  assign tsum = {7'd0, total_r} + {1'b0, sroot_r};

  // divider and accumulator steps
  logic [7:0]     div_sh, base_sum;
  logic           div_ge, base_wrap, off_wrap;
  logic [ORW-1:0] off_sum;
  always_comb begin
    div_sh    = {div_rem_r, (div_cnt_r == 6'd32)};
    div_ge    = (div_sh >= {1'b0, steps_r});
    base_sum  = {1'b0, base_rem_r} + {1'b0, div_rem_r};
    base_wrap = (base_sum >= {1'b0, steps_r});
    off_sum   = off_rem_r + OFF_R;
    off_wrap  = (off_sum >= ORW'(AGENTS));
  end

  // next permutation in lexicographic order
  logic [IW-1:0] piv, swp;
  logic [IW-1:0] ptmp [AGENTS];
  logic [IW-1:0] pt;
  always_comb begin
    piv       = '0;
    swp       = '0;
    perm_more = 1'b0;
    for (int a = 0; a < AGENTS - 1; a++) begin
      if (trial_r[a] < trial_r[a+1]) begin
        piv       = IW'(a);
        perm_more = 1'b1;
      end
    end
    for (int b = 0; b < AGENTS; b++) begin
      if (trial_r[b] > trial_r[piv]) swp = IW'(b);
    end
    for (int c = 0; c < AGENTS; c++) ptmp[c] = trial_r[c];
    pt         = ptmp[piv];
    ptmp[piv]  = ptmp[swp];
    ptmp[swp]  = pt;
    for (int c = 0; c < AGENTS; c++) begin
      if (IW'(c) > piv) perm_nxt[c] = ptmp[IW'(AGENTS + int'(piv) - c)];
      else              perm_nxt[c] = ptmp[c];
    end
  end

  // clamped phase steps and slot height of a new search
  logic [6:0] steps_v;
  logic signed [WW-1:0] cz_v, mh_v;
  always_comb begin
    if (phase_steps_r < STEPS_MIN)      steps_v = STEPS_MIN;
    else if (phase_steps_r > STEPS_MAX) steps_v = STEPS_MAX;
    else                                steps_v = phase_steps_r;
    cz_v = WW'(in_ring_center_z);
    mh_v = $signed(WW'(min_height_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_final_agent) state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == 6'd0) state_nxt = ST_ANGLE;
      ST_ANGLE: state_nxt = ST_ROT;
      ST_ROT:   if (it_r == 5'(TRIGS - 1)) state_nxt = ST_MULX;
      ST_MULX:  state_nxt = ST_MULY;
      ST_MULY:  state_nxt = ST_MULW;
      ST_MULW:  state_nxt = (slot_r == LAST_A) ? ST_DIFF : ST_ANGLE;
      ST_DIFF:  state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SQZ;
      ST_SQZ:   state_nxt = ST_SQADD;
      ST_SQADD: state_nxt = ST_ROOT;
      ST_ROOT:  if (scnt_r == 5'd31) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (ag_r == LAST_A) ? ST_CMP : ST_DIFF;
      ST_CMP: begin
        if (perm_more)                          state_nxt = ST_DIFF;
        else if (k_r == 6'(steps_r - 7'd1))     state_nxt = ST_OUT;
        else                                    state_nxt = ST_ANGLE;
      end
      ST_OUT:   if (out_acc && out_final_result) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_steps_r <= PHASE_STEPS_RST;
      min_height_r  <= MIN_HEIGHT_RST;
      load_cnt_r    <= '0;
      best_total_r  <= COST_MAX;
      best_phase_r  <= '0;
      out_idx_r     <= '0;
      for (int i = 0; i < AGENTS; i++) begin
        trial_r[i]     <= IW'(i);
        best_perm_r[i] <= IW'(i);
      end
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_STEPS: phase_steps_r <= cfg_data[6:0];
          CFG_MIN_HEIGHT:  min_height_r  <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (load_cnt_r < LCW'(AGENTS)) begin
              pos_x_r[load_cnt_r[IW-1:0]] <= in_agent_x;
              pos_y_r[load_cnt_r[IW-1:0]] <= in_agent_y;
              pos_z_r[load_cnt_r[IW-1:0]] <= in_agent_z;
            end
            if (in_final_agent) begin
              load_cnt_r   <= '0;
              cx_r         <= WW'(in_ring_center_x);
              cy_r         <= WW'(in_ring_center_y);
              zslot_r      <= (mh_v > cz_v) ? mh_v : cz_v;
              radius_r     <= in_ring_radius;
              steps_r      <= steps_v;
              div_rem_r    <= '0;
              div_q_r      <= '0;
              div_cnt_r    <= 6'd32;
              best_total_r <= COST_MAX;
              best_phase_r <= '0;
              for (int i = 0; i < AGENTS; i++) best_perm_r[i] <= IW'(i);
            end else if (load_cnt_r < LCW'(AGENTS)) begin
              load_cnt_r <= load_cnt_r + LCW'(1);
            end
          end
        end
        ST_DIV: begin
          div_rem_r <= div_ge ? 7'(div_sh - {1'b0, steps_r}) : div_sh[6:0];
          div_q_r   <= {div_q_r[30:0], div_ge};
          div_cnt_r <= div_cnt_r - 6'd1;
          k_r        <= '0;
          base_q_r   <= '0;
          base_rem_r <= '0;
          slot_r     <= '0;
          off_q_r    <= '0;
          off_rem_r  <= '0;
        end
        ST_ANGLE: begin
          cor_x_r <= CORDIC_K;
          cor_y_r <= '0;
          cor_z_r <= 34'($signed(ang_fold));
          neg_r   <= ang_neg;
          it_r    <= '0;
        end
        ST_ROT: begin
          cor_x_r <= rot_x;
          cor_y_r <= rot_y;
          cor_z_r <= rot_z;
          it_r    <= it_r + 5'd1;
        end
        ST_MULX: rprod_r <= rprod_v;
        ST_MULY: begin
          px_r[slot_r] <= cx_r + roff_v;
          rprod_r      <= rprod_v;
        end
        ST_MULW: begin
          py_r[slot_r] <= cy_r + roff_v;
          if (slot_r == LAST_A) begin
            for (int i = 0; i < AGENTS; i++) trial_r[i] <= IW'(i);
            ag_r    <= '0;
            total_r <= '0;
          end else begin
            slot_r    <= slot_r + IW'(1);
            off_q_r   <= off_q_r + OFF_Q + 32'(off_wrap);
            off_rem_r <= off_wrap ? (off_sum - ORW'(AGENTS)) : off_sum;
          end
        end
        ST_DIFF: begin
          capx_r <= cap_abs(dx_v);
          capy_r <= cap_abs(dy_v);
          capz_r <= cap_abs(dz_v);
        end
        ST_SQX: sq_r <= sq_v;
        ST_SQY: begin
          sum_r <= 64'(sq_r);
          sq_r  <= sq_v;
        end
        ST_SQZ: begin
          sum_r <= sum_r + 64'(sq_r);
          sq_r  <= sq_v;
        end
        ST_SQADD: begin
          sn_r    <= sum_r + 64'(sq_r);
          srem_r  <= '0;
          sroot_r <= '0;
          scnt_r  <= '0;
        end
        ST_ROOT: begin
          srem_r  <= rge ? 34'(rem2 - rtry) : rem2[33:0];
          sroot_r <= {sroot_r[30:0], rge};
          sn_r    <= {sn_r[61:0], 2'b00};
          scnt_r  <= scnt_r + 5'd1;
        end
        ST_ACC: begin
          total_r <= (tsum > 33'(COST_MAX)) ? COST_MAX : tsum[25:0];
          if (ag_r != LAST_A) ag_r <= ag_r + IW'(1);
        end
        ST_CMP: begin
          if (total_r < best_total_r) begin
            best_total_r <= total_r;
            best_phase_r <= k_r;
            for (int i = 0; i < AGENTS; i++) best_perm_r[i] <= trial_r[i];
          end
          if (perm_more) begin
            for (int i = 0; i < AGENTS; i++) trial_r[i] <= perm_nxt[i];
            ag_r    <= '0;
            total_r <= '0;
          end else if (k_r != 6'(steps_r - 7'd1)) begin
            k_r        <= k_r + 6'd1;
            base_q_r   <= base_q_r + div_q_r + 32'(base_wrap);
            base_rem_r <= base_wrap ? 7'(base_sum - {1'b0, steps_r}) : base_sum[6:0];
            slot_r     <= '0;
            off_q_r    <= '0;
            off_rem_r  <= '0;
          end else begin
            out_idx_r <= '0;
          end
        end
        ST_OUT: begin
          if (out_acc) out_idx_r <= out_final_result ? '0 : out_idx_r + IW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/rsmca_checker.sv
// port-level checker for the ring slot assignment block, bound to the top level
`timescale 1ns / 1ps
module rsmca_checker
  import rsmca_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_agent_index,
  input logic [25:0] out_total_cost,
  input logic        out_final_result
);

  // no new item is taken while results are pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while results pending");

  // results of one search follow each other in agent order
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_final_result) |=>
      (out_valid && out_agent_index == $past(out_agent_index) + 3'd1))
    else $error("result sequence broken");

  // the run ends after its last result
  a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_final_result) |=> !out_valid)
    else $error("result after last of run");

  // the total is the same on every result of a run
  a_cost_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_final_result) |=> $stable(out_total_cost))
    else $error("total cost changed within a run");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_agent_index)))
    else $error("stalled result dropped");

endmodule

bind ring_slot_min_cost_assignment rsmca_checker u_rsmca_checker (.*);
